// File: hdl/rvenc_pkg.sv
// Shared types, opcodes and mnemonic codes for the RV64I instruction encoder.
package rvenc_pkg;

  // Major opcodes
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_OPI    = 7'h13;
  localparam logic [6:0] OPC_OP32   = 7'h3B;
  localparam logic [6:0] OPC_OPI32  = 7'h1B;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_MISC   = 7'h0F;

  // funct3 / funct7 values
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;
  localparam logic [2:0] F3_B    = 3'd0;
  localparam logic [2:0] F3_H    = 3'd1;
  localparam logic [2:0] F3_W    = 3'd2;
  localparam logic [2:0] F3_D    = 3'd3;
  localparam logic [2:0] F3_BU   = 3'd4;
  localparam logic [2:0] F3_HU   = 3'd5;
  localparam logic [2:0] F3_WU   = 3'd6;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [6:0] F7_NONE = 7'h00;

  localparam logic [4:0]  REG_ZERO = 5'd0;
  localparam logic [11:0] IMM_ZERO = 12'h000;
  localparam logic [11:0] IMM_ONE  = 12'h001;
  localparam logic [11:0] IMM_ONES = 12'hFFF;

  // Mnemonic codes: base instructions, then pseudo-instructions
  typedef enum logic [6:0] {
    K_ADD, K_ADDI, K_ADDW, K_ADDIW, K_SUB, K_SUBW, K_AND, K_ANDI,
    K_OR, K_ORI, K_XOR, K_XORI, K_SLL, K_SLLI, K_SLLW, K_SLLIW,
    K_SRL, K_SRLI, K_SRLW, K_SRLIW, K_SRA, K_SRAI, K_SRAW, K_SRAIW,
    K_SLT, K_SLTI, K_SLTU, K_SLTIU, K_BEQ, K_BNE, K_BGE, K_BGEU,
    K_BLT, K_BLTU, K_JAL, K_JALR, K_ECALL, K_EBREAK, K_LB, K_LH,
    K_LW, K_LD, K_LBU, K_LHU, K_LWU, K_SB, K_SH, K_SW,
    K_SD, K_LUI, K_AUIPC, K_FENCE,
    K_NOP, K_LI, K_LA, K_MV, K_NOT, K_NEG, K_NEGW, K_SEXTW,
    K_SEQZ, K_SNEZ, K_SLTZ, K_SGTZ, K_BEQZ, K_BNEZ, K_BLEZ, K_BGEZ,
    K_BLTZ, K_BGTZ, K_BGT, K_BLE, K_BGTU, K_BLEU
  } kind_e;

  // Word layouts after decode
  typedef enum logic [2:0] {
    FMT_R, FMT_I, FMT_S, FMT_B, FMT_J, FMT_U, FMT_PAIR, FMT_BAD
  } fmt_e;

  typedef struct packed {
    logic [6:0]  kind;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm;
    logic [31:0] target;
    logic [31:0] position;
  } in_t;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
    logic        bad_kind;
  } out_t;

  // Normalized instruction after the decode stage
  typedef struct packed {
    fmt_e        fmt;
    logic [6:0]  op;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [11:0] imm12;
    logic [31:0] val;
  } dec_t;

  // Packed words after the pack stage
  typedef struct packed {
    logic [31:0] word0;
    logic [31:0] word1;
    logic        pair;
    logic        bad;
  } pack_t;

endpackage

// File: hdl/rvenc_decode.sv
// Stage 1: map the mnemonic to a word layout and compute the pc-relative offset.
module rvenc_decode (
  input  logic            clk,
  input  logic            rst,
  input  rvenc_pkg::in_t  in_data,
  input  logic            in_valid,
  output logic            in_ready,
  output rvenc_pkg::dec_t dec,
  output logic            dec_valid,
  input  logic            dec_ready
);
  import rvenc_pkg::*;

  localparam logic [11:0] ImmArith = 12'h400;

  dec_t        dec_next;
  logic        sel_off;
  logic [31:0] off_base;
  logic [31:0] off;

  // Offset: jal uses imm as target, everything else the label target
  assign off_base = (in_data.kind == K_JAL) ? in_data.imm : in_data.target;
  assign off      = off_base - in_data.position;

  // Decode mnemonic into layout, opcode, functs and register slots
  always_comb begin
    dec_next       = '0;
    dec_next.fmt   = FMT_BAD;
    dec_next.rd    = in_data.rd;
    dec_next.rs1   = in_data.rs1;
    dec_next.rs2   = in_data.rs2;
    dec_next.imm12 = in_data.imm[11:0];
    sel_off        = 1'b0;
    case (in_data.kind)
      K_ADD:   begin dec_next.fmt = FMT_R; dec_next.op = OPC_OP; end
      K_ADDW:  begin dec_next.fmt = FMT_R; dec_next.op = OPC_OP32; end
      K_SUB:   begin dec_next.fmt = FMT_R; dec_next.op = OPC_OP; dec_next.f7 = F7_ALT; end
      K_SUBW:  begin dec_next.fmt = FMT_R; dec_next.op = OPC_OP32; dec_next.f7 = F7_ALT; end
      K_AND:   begin dec_next.fmt = FMT_R; dec_next.op = OPC_OP; dec_next.f3 = F3_AND; end
      K_OR:    begin dec_next.fmt = FMT_R; dec_next.op = OPC_OP; dec_next.f3 = F3_OR; end
      K_XOR:   begin dec_next.fmt = FMT_R; dec_next.op = OPC_OP; dec_next.f3 = F3_XOR; end
      K_SLL:   begin dec_next.fmt = FMT_R; dec_next.op = OPC_OP; dec_next.f3 = F3_SLL; end
      K_SLLW:  begin dec_next.fmt = FMT_R; dec_next.op = OPC_OP32; dec_next.f3 = F3_SLL; end
      K_SRL:   begin dec_next.fmt = FMT_R; dec_next.op = OPC_OP; dec_next.f3 = F3_SR; end
      K_SRLW:  begin dec_next.fmt = FMT_R; dec_next.op = OPC_OP32; dec_next.f3 = F3_SR; end
      K_SRA: begin
        dec_next.fmt = FMT_R; dec_next.op = OPC_OP; dec_next.f3 = F3_SR;
        dec_next.f7  = F7_ALT;
      end
      K_SRAW: begin
        dec_next.fmt = FMT_R; dec_next.op = OPC_OP32; dec_next.f3 = F3_SR;
        dec_next.f7  = F7_ALT;
      end
      K_SLT:   begin dec_next.fmt = FMT_R; dec_next.op = OPC_OP; dec_next.f3 = F3_SLT; end
      K_SLTU:  begin dec_next.fmt = FMT_R; dec_next.op = OPC_OP; dec_next.f3 = F3_SLTU; end
      K_ADDI:  begin dec_next.fmt = FMT_I; dec_next.op = OPC_OPI; end
      K_ADDIW: begin dec_next.fmt = FMT_I; dec_next.op = OPC_OPI32; end
      K_ANDI:  begin dec_next.fmt = FMT_I; dec_next.op = OPC_OPI; dec_next.f3 = F3_AND; end
      K_ORI:   begin dec_next.fmt = FMT_I; dec_next.op = OPC_OPI; dec_next.f3 = F3_OR; end
      K_XORI:  begin dec_next.fmt = FMT_I; dec_next.op = OPC_OPI; dec_next.f3 = F3_XOR; end
      K_SLLI:  begin dec_next.fmt = FMT_I; dec_next.op = OPC_OPI; dec_next.f3 = F3_SLL; end
      K_SLLIW: begin dec_next.fmt = FMT_I; dec_next.op = OPC_OPI32; dec_next.f3 = F3_SLL; end
      K_SRLI:  begin dec_next.fmt = FMT_I; dec_next.op = OPC_OPI; dec_next.f3 = F3_SR; end
      K_SRLIW: begin dec_next.fmt = FMT_I; dec_next.op = OPC_OPI32; dec_next.f3 = F3_SR; end
      // arithmetic shifts: force bit 30, shift amount left unmasked
      K_SRAI: begin
        dec_next.fmt   = FMT_I; dec_next.op = OPC_OPI; dec_next.f3 = F3_SR;
        dec_next.imm12 = in_data.imm[11:0] | ImmArith;
      end
      K_SRAIW: begin
        dec_next.fmt   = FMT_I; dec_next.op = OPC_OPI32; dec_next.f3 = F3_SR;
        dec_next.imm12 = in_data.imm[11:0] | ImmArith;
      end
      K_SLTI:  begin dec_next.fmt = FMT_I; dec_next.op = OPC_OPI; dec_next.f3 = F3_SLT; end
      K_SLTIU: begin dec_next.fmt = FMT_I; dec_next.op = OPC_OPI; dec_next.f3 = F3_SLTU; end
      K_JALR:  begin dec_next.fmt = FMT_I; dec_next.op = OPC_JALR; end
      K_LB:    begin dec_next.fmt = FMT_I; dec_next.op = OPC_LOAD; dec_next.f3 = F3_B; end
      K_LH:    begin dec_next.fmt = FMT_I; dec_next.op = OPC_LOAD; dec_next.f3 = F3_H; end
      K_LW:    begin dec_next.fmt = FMT_I; dec_next.op = OPC_LOAD; dec_next.f3 = F3_W; end
      K_LD:    begin dec_next.fmt = FMT_I; dec_next.op = OPC_LOAD; dec_next.f3 = F3_D; end
      K_LBU:   begin dec_next.fmt = FMT_I; dec_next.op = OPC_LOAD; dec_next.f3 = F3_BU; end
      K_LHU:   begin dec_next.fmt = FMT_I; dec_next.op = OPC_LOAD; dec_next.f3 = F3_HU; end
      K_LWU:   begin dec_next.fmt = FMT_I; dec_next.op = OPC_LOAD; dec_next.f3 = F3_WU; end
      // system and fence: no register fields
      K_ECALL, K_EBREAK: begin
        dec_next.fmt   = FMT_I; dec_next.op = OPC_SYSTEM;
        dec_next.rd    = REG_ZERO; dec_next.rs1 = REG_ZERO;
        dec_next.imm12 = (in_data.kind == K_EBREAK) ? IMM_ONE : IMM_ZERO;
      end
      K_FENCE: begin
        dec_next.fmt = FMT_I; dec_next.op = OPC_MISC;
        dec_next.rd  = REG_ZERO; dec_next.rs1 = REG_ZERO;
      end
      K_SB:    begin dec_next.fmt = FMT_S; dec_next.op = OPC_STORE; dec_next.f3 = F3_B; end
      K_SH:    begin dec_next.fmt = FMT_S; dec_next.op = OPC_STORE; dec_next.f3 = F3_H; end
      K_SW:    begin dec_next.fmt = FMT_S; dec_next.op = OPC_STORE; dec_next.f3 = F3_W; end
      K_SD:    begin dec_next.fmt = FMT_S; dec_next.op = OPC_STORE; dec_next.f3 = F3_D; end
      // base branches: first source travels in rd
      K_BEQ, K_BNE, K_BGE, K_BGEU, K_BLT, K_BLTU: begin
        dec_next.fmt = FMT_B; dec_next.op = OPC_BRANCH;
        dec_next.rs1 = in_data.rd; sel_off = 1'b1;
        case (in_data.kind)
          K_BEQ:   dec_next.f3 = F3_BEQ;
          K_BNE:   dec_next.f3 = F3_BNE;
          K_BGE:   dec_next.f3 = F3_BGE;
          K_BGEU:  dec_next.f3 = F3_BGEU;
          K_BLT:   dec_next.f3 = F3_BLT;
          default: dec_next.f3 = F3_BLTU;
        endcase
      end
      K_JAL:   begin dec_next.fmt = FMT_J; dec_next.op = OPC_JAL; sel_off = 1'b1; end
      K_LUI:   begin dec_next.fmt = FMT_U; dec_next.op = OPC_LUI; end
      K_AUIPC: begin dec_next.fmt = FMT_U; dec_next.op = OPC_AUIPC; end
      K_NOP: begin
        dec_next.fmt = FMT_I; dec_next.op = OPC_OPI;
        dec_next.rd  = REG_ZERO; dec_next.rs1 = REG_ZERO; dec_next.imm12 = IMM_ZERO;
      end
      K_LI:    begin dec_next.fmt = FMT_PAIR; dec_next.op = OPC_LUI; end
      K_LA:    begin dec_next.fmt = FMT_PAIR; dec_next.op = OPC_AUIPC; sel_off = 1'b1; end
      K_MV:    begin dec_next.fmt = FMT_I; dec_next.op = OPC_OPI; dec_next.imm12 = IMM_ZERO; end
      K_NOT: begin
        dec_next.fmt = FMT_I; dec_next.op = OPC_OPI; dec_next.f3 = F3_XOR;
        dec_next.imm12 = IMM_ONES;
      end
      K_NEG, K_NEGW: begin
        dec_next.fmt = FMT_R;
        dec_next.op  = (in_data.kind == K_NEGW) ? OPC_OP32 : OPC_OP;
        dec_next.f7  = F7_ALT;
        dec_next.rs1 = REG_ZERO; dec_next.rs2 = in_data.rs1;
      end
      K_SEXTW: begin dec_next.fmt = FMT_I; dec_next.op = OPC_OPI32; dec_next.imm12 = IMM_ZERO; end
      K_SEQZ: begin
        dec_next.fmt = FMT_I; dec_next.op = OPC_OPI; dec_next.f3 = F3_SLTU;
        dec_next.imm12 = IMM_ONE;
      end
      K_SNEZ, K_SGTZ: begin
        dec_next.fmt = FMT_R; dec_next.op = OPC_OP;
        dec_next.f3  = (in_data.kind == K_SNEZ) ? F3_SLTU : F3_SLT;
        dec_next.rs1 = REG_ZERO; dec_next.rs2 = in_data.rs1;
      end
      K_SLTZ: begin
        dec_next.fmt = FMT_R; dec_next.op = OPC_OP; dec_next.f3 = F3_SLT;
        dec_next.rs2 = REG_ZERO;
      end
      // compare-with-zero branches: zero sits on one side, rd on the other
      K_BEQZ, K_BNEZ, K_BGEZ, K_BLTZ: begin
        dec_next.fmt = FMT_B; dec_next.op = OPC_BRANCH; sel_off = 1'b1;
        dec_next.rs1 = in_data.rd; dec_next.rs2 = REG_ZERO;
        case (in_data.kind)
          K_BEQZ:  dec_next.f3 = F3_BEQ;
          K_BNEZ:  dec_next.f3 = F3_BNE;
          K_BGEZ:  dec_next.f3 = F3_BGE;
          default: dec_next.f3 = F3_BLT;
        endcase
      end
      K_BLEZ, K_BGTZ: begin
        dec_next.fmt = FMT_B; dec_next.op = OPC_BRANCH; sel_off = 1'b1;
        dec_next.rs1 = REG_ZERO; dec_next.rs2 = in_data.rd;
        dec_next.f3  = (in_data.kind == K_BLEZ) ? F3_BGE : F3_BLT;
      end
      // swapped branches
      K_BGT, K_BLE, K_BGTU, K_BLEU: begin
        dec_next.fmt = FMT_B; dec_next.op = OPC_BRANCH; sel_off = 1'b1;
        dec_next.rs1 = in_data.rs2; dec_next.rs2 = in_data.rd;
        case (in_data.kind)
          K_BGT:   dec_next.f3 = F3_BLT;
          K_BLE:   dec_next.f3 = F3_BGE;
          K_BGTU:  dec_next.f3 = F3_BLTU;
          default: dec_next.f3 = F3_BGEU;
        endcase
      end
      default: dec_next.fmt = FMT_BAD;
    endcase
    dec_next.val = sel_off ? off : in_data.imm;
  end

  assign in_ready = !dec_valid || dec_ready;

  // Advance the stage valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else if (in_ready) begin
      dec_valid <= in_valid;
    end
  end

  // Load the stage payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      dec <= dec_next;
    end
  end

endmodule

// File: hdl/rvenc_pack.sv
// Stage 2: pack the decoded fields into one or two 32-bit instruction words.
module rvenc_pack (
  input  logic             clk,
  input  logic             rst,
  input  rvenc_pkg::dec_t  dec,
  input  logic             dec_valid,
  output logic             dec_ready,
  output rvenc_pkg::pack_t pack,
  output logic             pack_valid,
  input  logic             pack_ready
);
  import rvenc_pkg::*;

  pack_t       pack_next;
  logic [19:0] upper;

  // Round the upper part so the sign-extended low part adds back exactly
  assign upper = dec.val[31:12] + {19'd0, dec.val[11]};

  // Build the words for each layout
  always_comb begin
    pack_next = '0;
    case (dec.fmt)
      FMT_R: pack_next.word0 = {dec.f7, dec.rs2, dec.rs1, dec.f3, dec.rd, dec.op};
      FMT_I: pack_next.word0 = {dec.imm12, dec.rs1, dec.f3, dec.rd, dec.op};
      FMT_S: pack_next.word0 = {dec.imm12[11:5], dec.rs2, dec.rs1, dec.f3,
                                dec.imm12[4:0], dec.op};
      FMT_B: pack_next.word0 = {dec.val[12], dec.val[10:5], dec.rs2, dec.rs1, dec.f3,
                                dec.val[4:1], dec.val[11], dec.op};
      FMT_J: pack_next.word0 = {dec.val[20], dec.val[10:1], dec.val[11], dec.val[19:12],
                                dec.rd, dec.op};
      FMT_U: pack_next.word0 = {dec.val[31:12], dec.rd, dec.op};
      FMT_PAIR: begin
        pack_next.word0 = {upper, dec.rd, dec.op};
        pack_next.word1 = {dec.val[11:0], dec.rd, F3_ADD, dec.rd, OPC_OPI};
        pack_next.pair  = 1'b1;
      end
      default: pack_next.bad = 1'b1;
    endcase
  end

  assign dec_ready = !pack_valid || pack_ready;

  // Advance the stage valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      pack_valid <= 1'b0;
    end else if (dec_ready) begin
      pack_valid <= dec_valid;
    end
  end

  // Load the stage payload
  always_ff @(posedge clk) begin
    if (dec_ready && dec_valid) begin
      pack <= pack_next;
    end
  end

endmodule

// File: hdl/rvenc_emit.sv
// Stage 3: output register that hands out one word, or both words of a pair.
module rvenc_emit (
  input  logic             clk,
  input  logic             rst,
  input  rvenc_pkg::pack_t pack,
  input  logic             pack_valid,
  output logic             pack_ready,
  output rvenc_pkg::out_t  out_data,
  output logic             out_valid,
  input  logic             out_stall
);
  import rvenc_pkg::*;

  pack_t hold;
  logic  phase;
  logic  last;

  assign last       = !hold.pair || phase;
  assign pack_ready = !out_valid || (!out_stall && last);

  // Drive the current word
  assign out_data.word     = phase ? hold.word1 : hold.word0;
  assign out_data.last     = last;
  assign out_data.bad_kind = hold.bad;

  // Take a new item once the last word has gone; else step to the second word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (pack_ready) begin
      out_valid <= pack_valid;
      phase     <= 1'b0;
    end else if (!out_stall) begin
      phase     <= 1'b1;
    end
  end

  // Hold the packed words
  always_ff @(posedge clk) begin
    if (pack_ready && pack_valid) begin
      hold <= pack;
    end
  end

  // A first word that transfers is followed by the last word of the pair
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !last && !out_stall |=> out_valid && last && phase)
    else $error("second word of pair not presented");

  // An unknown mnemonic gives a single zero word
  assert property (@(posedge clk) disable iff (rst)
    out_valid && hold.bad |-> last && (out_data.word == '0) && !hold.pair)
    else $error("bad kind result malformed");

  // The second-word phase exists only for a valid pair
  assert property (@(posedge clk) disable iff (rst)
    phase |-> out_valid && hold.pair)
    else $error("phase set without a pair in the output register");

endmodule

// File: hdl/riscv_instruction_encoder_unit.sv
// Top level of the RV64I instruction encoder: three-stage pipeline.
//
// Input channel (in_valid / in_stall / in_data): one mnemonic with its
// register numbers, immediate, label target and instruction position.
// Output channel (out_valid / out_stall / out_data): encoded 32-bit words.
// Each item yields one word with last set, except li and la, which yield an
// upper word (lui/auipc) and then an addi word with last set. An unknown
// mnemonic yields one zero word with bad_kind and last set.
// Each item passes through the decode, pack and output registers before its
// first word is presented.
// Throughput: one item per cycle while out_stall is low; li and la occupy the
// output register for both of their words, so they hold up the items behind.
// Reset (rst, synchronous) empties all stages; the payload registers are not reset.
// When the receiver stalls, the presented word holds and the stages behind
// it keep filling up; in_stall rises once every stage is occupied.
module riscv_instruction_encoder_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  rvenc_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output rvenc_pkg::out_t out_data
);
  import rvenc_pkg::*;

  dec_t  dec;
  logic  dec_valid;
  logic  dec_ready;
  pack_t pack;
  logic  pack_valid;
  logic  pack_ready;
  logic  in_ready;

  assign in_stall = !in_ready;

  rvenc_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .dec       (dec),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready)
  );

  rvenc_pack u_pack (
    .clk        (clk),
    .rst        (rst),
    .dec        (dec),
    .dec_valid  (dec_valid),
    .dec_ready  (dec_ready),
    .pack       (pack),
    .pack_valid (pack_valid),
    .pack_ready (pack_ready)
  );

  rvenc_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .pack       (pack),
    .pack_valid (pack_valid),
    .pack_ready (pack_ready),
    .out_data   (out_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall)
  );

endmodule

// File: bench/tb_riscv_instruction_encoder_unit.sv
// Self-checking testbench for the RV64I instruction encoder unit.
module tb_riscv_instruction_encoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import rvenc_pkg::*;

  localparam int          IDLE_PCT     = 6;
  localparam int          HOLD_AT      = 1300;
  localparam int          HOLD_LEN     = 300;
  localparam int          PRINT_CAP    = 100;
  localparam logic [6:0]  KIND_BAD_LO  = 7'(K_BLEU) + 7'd1;
  localparam logic [6:0]  KIND_BAD_HI  = 7'h7F;
  localparam logic [31:0] SRA_ALT_BIT  = 32'h4000_0000;
  localparam logic [31:0] UPPER_ROUND  = 32'h0000_0800;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  in_t  mnemonics_to_send[$];
  out_t words_due[$];
  int   items_queued = 0;
  int   items_taken = 0;
  int   errors = 0;
  logic in_xfer = 1'b0;
  logic steady = 1'b0;
  logic held_once = 1'b0;
  int   hold_left = 0;

  riscv_instruction_encoder_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Instruction field packers
  function automatic logic [31:0] pack_r(logic [6:0] op, logic [2:0] f3, logic [6:0] f7,
                                         logic [4:0] d, logic [4:0] s1, logic [4:0] s2);
    return {f7, s2, s1, f3, d, op};
  endfunction

  function automatic logic [31:0] pack_i(logic [6:0] op, logic [2:0] f3, logic [4:0] d,
                                         logic [4:0] s1, logic [11:0] im);
    return {im, s1, f3, d, op};
  endfunction

  function automatic logic [31:0] pack_s(logic [2:0] f3, logic [4:0] s1, logic [4:0] s2,
                                         logic [11:0] im);
    return {im[11:5], s2, s1, f3, im[4:0], OPC_STORE};
  endfunction

  function automatic logic [31:0] pack_b(logic [2:0] f3, logic [4:0] s1, logic [4:0] s2,
                                         logic [31:0] off);
    return {off[12], off[10:5], s2, s1, f3, off[4:1], off[11], OPC_BRANCH};
  endfunction

  function automatic logic [31:0] pack_j(logic [4:0] d, logic [31:0] off);
    return {off[20], off[10:1], off[11], off[19:12], d, OPC_JAL};
  endfunction

  function automatic logic [31:0] pack_u(logic [6:0] op, logic [4:0] d, logic [31:0] val);
    return {val[31:12], d, op};
  endfunction

  // Work out the words one mnemonic encodes to and queue them
  function automatic void predict_encoding(in_t it);
    logic [31:0] boff;
    logic [31:0] joff;
    logic [31:0] val;
    logic [31:0] w;
    logic [11:0] im;
    out_t        r;
    boff = it.target - it.position;
    joff = it.imm - it.position;
    im   = it.imm[11:0];
    w    = '0;
    r    = '{word: '0, last: 1'b1, bad_kind: 1'b0};
    case (it.kind)
      K_ADD:    w = pack_r(OPC_OP,   F3_ADD,  F7_NONE, it.rd, it.rs1, it.rs2);
      K_ADDI:   w = pack_i(OPC_OPI,  F3_ADD,  it.rd, it.rs1, im);
      K_ADDW:   w = pack_r(OPC_OP32, F3_ADD,  F7_NONE, it.rd, it.rs1, it.rs2);
      K_ADDIW:  w = pack_i(OPC_OPI32, F3_ADD, it.rd, it.rs1, im);
      K_SUB:    w = pack_r(OPC_OP,   F3_ADD,  F7_ALT,  it.rd, it.rs1, it.rs2);
      K_SUBW:   w = pack_r(OPC_OP32, F3_ADD,  F7_ALT,  it.rd, it.rs1, it.rs2);
      K_AND:    w = pack_r(OPC_OP,   F3_AND,  F7_NONE, it.rd, it.rs1, it.rs2);
      K_ANDI:   w = pack_i(OPC_OPI,  F3_AND,  it.rd, it.rs1, im);
      K_OR:     w = pack_r(OPC_OP,   F3_OR,   F7_NONE, it.rd, it.rs1, it.rs2);
      K_ORI:    w = pack_i(OPC_OPI,  F3_OR,   it.rd, it.rs1, im);
      K_XOR:    w = pack_r(OPC_OP,   F3_XOR,  F7_NONE, it.rd, it.rs1, it.rs2);
      K_XORI:   w = pack_i(OPC_OPI,  F3_XOR,  it.rd, it.rs1, im);
      K_SLL:    w = pack_r(OPC_OP,   F3_SLL,  F7_NONE, it.rd, it.rs1, it.rs2);
      K_SLLI:   w = pack_i(OPC_OPI,  F3_SLL,  it.rd, it.rs1, im);
      K_SLLW:   w = pack_r(OPC_OP32, F3_SLL,  F7_NONE, it.rd, it.rs1, it.rs2);
      K_SLLIW:  w = pack_i(OPC_OPI32, F3_SLL, it.rd, it.rs1, im);
      K_SRL:    w = pack_r(OPC_OP,   F3_SR,   F7_NONE, it.rd, it.rs1, it.rs2);
      K_SRLI:   w = pack_i(OPC_OPI,  F3_SR,   it.rd, it.rs1, im);
      K_SRLW:   w = pack_r(OPC_OP32, F3_SR,   F7_NONE, it.rd, it.rs1, it.rs2);
      K_SRLIW:  w = pack_i(OPC_OPI32, F3_SR,  it.rd, it.rs1, im);
      K_SRA:    w = pack_r(OPC_OP,   F3_SR,   F7_ALT,  it.rd, it.rs1, it.rs2);
      K_SRAI:   w = pack_i(OPC_OPI,  F3_SR,   it.rd, it.rs1, im) | SRA_ALT_BIT;
      K_SRAW:   w = pack_r(OPC_OP32, F3_SR,   F7_ALT,  it.rd, it.rs1, it.rs2);
      K_SRAIW:  w = pack_i(OPC_OPI32, F3_SR,  it.rd, it.rs1, im) | SRA_ALT_BIT;
      K_SLT:    w = pack_r(OPC_OP,   F3_SLT,  F7_NONE, it.rd, it.rs1, it.rs2);
      K_SLTI:   w = pack_i(OPC_OPI,  F3_SLT,  it.rd, it.rs1, im);
      K_SLTU:   w = pack_r(OPC_OP,   F3_SLTU, F7_NONE, it.rd, it.rs1, it.rs2);
      K_SLTIU:  w = pack_i(OPC_OPI,  F3_SLTU, it.rd, it.rs1, im);
      K_BEQ:    w = pack_b(F3_BEQ,  it.rd, it.rs2, boff);
      K_BNE:    w = pack_b(F3_BNE,  it.rd, it.rs2, boff);
      K_BGE:    w = pack_b(F3_BGE,  it.rd, it.rs2, boff);
      K_BGEU:   w = pack_b(F3_BGEU, it.rd, it.rs2, boff);
      K_BLT:    w = pack_b(F3_BLT,  it.rd, it.rs2, boff);
      K_BLTU:   w = pack_b(F3_BLTU, it.rd, it.rs2, boff);
      K_JAL:    w = pack_j(it.rd, joff);
      K_JALR:   w = pack_i(OPC_JALR, F3_ADD, it.rd, it.rs1, im);
      K_ECALL:  w = pack_i(OPC_SYSTEM, F3_ADD, REG_ZERO, REG_ZERO, IMM_ZERO);
      K_EBREAK: w = pack_i(OPC_SYSTEM, F3_ADD, REG_ZERO, REG_ZERO, IMM_ONE);
      K_LB:     w = pack_i(OPC_LOAD, F3_B,  it.rd, it.rs1, im);
      K_LH:     w = pack_i(OPC_LOAD, F3_H,  it.rd, it.rs1, im);
      K_LW:     w = pack_i(OPC_LOAD, F3_W,  it.rd, it.rs1, im);
      K_LD:     w = pack_i(OPC_LOAD, F3_D,  it.rd, it.rs1, im);
      K_LBU:    w = pack_i(OPC_LOAD, F3_BU, it.rd, it.rs1, im);
      K_LHU:    w = pack_i(OPC_LOAD, F3_HU, it.rd, it.rs1, im);
      K_LWU:    w = pack_i(OPC_LOAD, F3_WU, it.rd, it.rs1, im);
      K_SB:     w = pack_s(F3_B, it.rs1, it.rs2, im);
      K_SH:     w = pack_s(F3_H, it.rs1, it.rs2, im);
      K_SW:     w = pack_s(F3_W, it.rs1, it.rs2, im);
      K_SD:     w = pack_s(F3_D, it.rs1, it.rs2, im);
      K_LUI:    w = pack_u(OPC_LUI, it.rd, it.imm);
      K_AUIPC:  w = pack_u(OPC_AUIPC, it.rd, it.imm);
      K_FENCE:  w = pack_i(OPC_MISC, F3_ADD, REG_ZERO, REG_ZERO, im);
      K_NOP:    w = pack_i(OPC_OPI, F3_ADD, REG_ZERO, REG_ZERO, IMM_ZERO);
      K_LI, K_LA: begin
        // Upper word rounds so that the signed addi lands on the value
        val = (it.kind == K_LI) ? it.imm : boff;
        r.word = pack_u((it.kind == K_LI) ? OPC_LUI : OPC_AUIPC, it.rd, val + UPPER_ROUND);
        r.last = 1'b0;
        words_due.push_back(r);
        w = pack_i(OPC_OPI, F3_ADD, it.rd, it.rd, val[11:0]);
      end
      K_MV:     w = pack_i(OPC_OPI, F3_ADD, it.rd, it.rs1, IMM_ZERO);
      K_NOT:    w = pack_i(OPC_OPI, F3_XOR, it.rd, it.rs1, IMM_ONES);
      K_NEG:    w = pack_r(OPC_OP,   F3_ADD, F7_ALT, it.rd, REG_ZERO, it.rs1);
      K_NEGW:   w = pack_r(OPC_OP32, F3_ADD, F7_ALT, it.rd, REG_ZERO, it.rs1);
      K_SEXTW:  w = pack_i(OPC_OPI32, F3_ADD, it.rd, it.rs1, IMM_ZERO);
      K_SEQZ:   w = pack_i(OPC_OPI, F3_SLTU, it.rd, it.rs1, IMM_ONE);
      K_SNEZ:   w = pack_r(OPC_OP, F3_SLTU, F7_NONE, it.rd, REG_ZERO, it.rs1);
      K_SLTZ:   w = pack_r(OPC_OP, F3_SLT,  F7_NONE, it.rd, it.rs1, REG_ZERO);
      K_SGTZ:   w = pack_r(OPC_OP, F3_SLT,  F7_NONE, it.rd, REG_ZERO, it.rs1);
      K_BEQZ:   w = pack_b(F3_BEQ, it.rd, REG_ZERO, boff);
      K_BNEZ:   w = pack_b(F3_BNE, it.rd, REG_ZERO, boff);
      K_BLEZ:   w = pack_b(F3_BGE, REG_ZERO, it.rd, boff);
      K_BGEZ:   w = pack_b(F3_BGE, it.rd, REG_ZERO, boff);
      K_BLTZ:   w = pack_b(F3_BLT, it.rd, REG_ZERO, boff);
      K_BGTZ:   w = pack_b(F3_BLT, REG_ZERO, it.rd, boff);
      // Swapped branches: rs2 field comes first
      K_BGT:    w = pack_b(F3_BLT,  it.rs2, it.rd, boff);
      K_BLE:    w = pack_b(F3_BGE,  it.rs2, it.rd, boff);
      K_BGTU:   w = pack_b(F3_BLTU, it.rs2, it.rd, boff);
      K_BLEU:   w = pack_b(F3_BGEU, it.rs2, it.rd, boff);
      default:  r.bad_kind = 1'b1;
    endcase
    r.word = w;
    r.last = 1'b1;
    words_due.push_back(r);
  endfunction

  function automatic in_t make_item(logic [6:0] kind, logic [4:0] rd, logic [4:0] rs1,
                                    logic [4:0] rs2, logic [31:0] imm, logic [31:0] target,
                                    logic [31:0] position);
    return '{kind: kind, rd: rd, rs1: rs1, rs2: rs2, imm: imm, target: target,
             position: position};
  endfunction

  function automatic in_t random_item();
    in_t         it;
    int          ofs;
    logic [31:0] corner;
    it.kind = ($urandom_range(99) < 5) ? 7'($urandom_range(KIND_BAD_HI, KIND_BAD_LO))
                                       : 7'($urandom_range(K_BLEU, K_ADD));
    it.rd       = 5'($urandom());
    it.rs1      = 5'($urandom());
    it.rs2      = 5'($urandom());
    it.position = $urandom();
    // Half the labels sit within branch reach of the instruction
    ofs = int'($urandom_range(8191)) - 4096;
    it.target = $urandom_range(1) ? it.position + 32'(ofs) : $urandom();
    case ($urandom_range(5))
      0:       corner = 32'h0000_0000;
      1:       corner = 32'hFFFF_FFFF;
      2:       corner = 32'h7FFF_FFFF;
      3:       corner = 32'h8000_0000;
      4:       corner = 32'h0000_07FF;
      default: corner = 32'h0000_0800;
    endcase
    case ($urandom_range(9))
      0, 1, 2, 3: it.imm = $urandom();
      4:          it.imm = it.position + 32'(int'($urandom_range(2097151)) - 1048576);
      5:          it.imm = corner;
      default:    it.imm = 32'(int'($urandom_range(4095)) - 2048);
    endcase
    return it;
  endfunction

  task automatic queue_item(in_t it);
    mnemonics_to_send.push_back(it);
    items_queued++;
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= PRINT_CAP) begin
      $display("%0t ns: %s mismatch: got %h, want %h", $time, what, got, want);
    end
  endtask

  // Sender: offer the next mnemonic once the current one has transferred
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_xfer)) begin
      if (mnemonics_to_send.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        in_data  <= mnemonics_to_send.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold to back the pipeline up
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!held_once && items_taken >= HOLD_AT) begin
      held_once <= 1'b1;
      hold_left <= HOLD_LEN;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Monitor: predict on input transfers, check output transfers in order
  always @(posedge clk) begin : monitor
    out_t want;
    in_xfer = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        in_xfer = 1'b1;
        items_taken++;
        predict_encoding(in_data);
      end
      if (out_valid && !out_stall) begin
        if (words_due.size() == 0) begin
          report_mismatch("unexpected word", out_data.word, '0);
        end else begin
          want = words_due.pop_front();
          if (out_data.word !== want.word) begin
            report_mismatch("word", out_data.word, want.word);
          end
          if (out_data.last !== want.last) begin
            report_mismatch("last", 32'(out_data.last), 32'(want.last));
          end
          if (out_data.bad_kind !== want.bad_kind) begin
            report_mismatch("bad_kind", 32'(out_data.bad_kind), 32'(want.bad_kind));
          end
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: field extremes and corner encodings
    queue_item(make_item(K_ADD, 5'd0, 5'd0, 5'd0, '0, '0, '0));
    queue_item(make_item(K_ADD, 5'd31, 5'd31, 5'd31, '1, '1, '1));
    queue_item(make_item(K_ADDI, 5'd1, 5'd2, 5'd3, 32'h7FFF_FFFF, '0, '0));
    queue_item(make_item(K_SRAI, 5'd5, 5'd6, 5'd7, 32'hFFFF_FFFF, '0, '0));
    queue_item(make_item(K_SRAIW, 5'd8, 5'd9, 5'd10, 32'h0000_0020, '0, '0));
    queue_item(make_item(K_SLLIW, 5'd11, 5'd12, 5'd13, 32'h0000_001F, '0, '0));
    queue_item(make_item(K_SD, 5'd9, 5'd10, 5'd11, 32'h8000_0FFF, '0, '0));
    queue_item(make_item(K_SB, 5'd0, 5'd31, 5'd1, 32'hFFFF_FFFF, '0, '0));
    queue_item(make_item(K_BEQ, 5'd1, 5'd2, 5'd3, '0, 32'h0000_0000, 32'hFFFF_F000));
    queue_item(make_item(K_BNE, 5'd4, 5'd0, 5'd5, '0, 32'h0000_1003, 32'h0000_1000));
    queue_item(make_item(K_BLTU, 5'd31, 5'd0, 5'd31, '0, 32'h8000_0001, 32'h0000_0000));
    queue_item(make_item(K_JAL, 5'd1, 5'd0, 5'd0, 32'h0000_0000, '0, 32'h0010_0000));
    queue_item(make_item(K_JAL, 5'd31, 5'd0, 5'd0, 32'hFFFF_FFFF, '0, 32'h0000_0000));
    queue_item(make_item(K_ECALL, 5'd31, 5'd31, 5'd31, '1, '1, '1));
    queue_item(make_item(K_EBREAK, 5'd0, 5'd0, 5'd0, '0, '0, '0));
    queue_item(make_item(K_FENCE, 5'd3, 5'd4, 5'd5, '1, '0, '0));
    queue_item(make_item(K_LUI, 5'd31, 5'd0, 5'd0, '1, '0, '0));
    queue_item(make_item(K_AUIPC, 5'd2, 5'd0, 5'd0, 32'h0000_0FFF, '0, '0));
    queue_item(make_item(K_LI, 5'd10, 5'd0, 5'd0, 32'h0000_07FF, '0, '0));
    queue_item(make_item(K_LI, 5'd11, 5'd0, 5'd0, 32'h0000_0800, '0, '0));
    queue_item(make_item(K_LI, 5'd12, 5'd0, 5'd0, 32'h7FFF_FFFF, '0, '0));
    queue_item(make_item(K_LI, 5'd31, 5'd0, 5'd0, 32'hFFFF_FFFF, '0, '0));
    queue_item(make_item(K_LA, 5'd13, 5'd0, 5'd0, '0, 32'h0000_0000, 32'h0000_0001));
    queue_item(make_item(K_LA, 5'd14, 5'd0, 5'd0, '0, 32'h0000_0800, 32'h0000_0000));
    queue_item(make_item(KIND_BAD_LO, 5'd31, 5'd31, 5'd31, '1, '1, '1));
    queue_item(make_item(KIND_BAD_HI, 5'd0, 5'd0, 5'd0, '0, '0, '0));
    queue_item(make_item(K_BLEU, 5'd7, 5'd0, 5'd21, '0, 32'h0000_0FFE, 32'h0000_1000));

    // Random traffic with idling on both sides
    repeat (700) queue_item(random_item());
    wait (items_taken == items_queued);

    // Back-to-back stretch with no idling
    steady = 1'b1;
    repeat (400) queue_item(random_item());
    wait (items_taken == items_queued);
    steady = 1'b0;

    // Random again; the receiver's long hold falls in here
    repeat (500) queue_item(random_item());
    wait (items_taken == items_queued);

    // Drain outstanding words, then give the pipeline time to misbehave
    while (words_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
